// ===== hw/rtl/ttad_pkg.sv =====
package ttad_pkg;

  // Fixed field widths
  localparam int PROB_W   = 16;
  localparam int TOK_W    = 6;
  localparam int DIM_W    = 13;
  localparam int SCALE_W  = 32;
  localparam int NUM_LOC  = 8;
  localparam int CFG_AW   = 6;
  localparam int CFG_DW   = 64;
  localparam int MASK_W   = 64;

  // Score accumulation: up to MAX_STEPS probabilities are summed
  localparam int MAX_STEPS = 1024;
  localparam int SC_W      = 11;
  localparam int SUM_W     = 26;

  // Default vocabulary size
  localparam int VOCAB_DEF = 64;

  // Queue between front and back
  localparam int Q_DEPTH = 2;

  // Register indexes (paddr[5:3])
  localparam logic [2:0] REG_PW    = 3'd0;
  localparam logic [2:0] REG_PH    = 3'd1;
  localparam logic [2:0] REG_OW    = 3'd2;
  localparam logic [2:0] REG_OH    = 3'd3;
  localparam logic [2:0] REG_START = 3'd4;
  localparam logic [2:0] REG_END   = 3'd5;
  localparam logic [2:0] REG_MASK  = 3'd6;

  typedef logic [NUM_LOC-1:0][PROB_W-1:0] loc_vec_t;

  // One decided row, as handed from front to back
  typedef struct packed {
    logic             tok;
    logic [TOK_W-1:0] idx;
    logic             cell_hit;
    loc_vec_t         loc;
    logic             done;
    logic [SUM_W-1:0] sum;
    logic [SC_W-1:0]  cnt;
  } ent_t;

  // Status seen by the front
  typedef struct packed {
    logic q_full;
    logic q_empty;
    logic back_idle;
    logic scale_busy;
  } fctl_t;

  // A zero size counts as one
  function automatic logic [DIM_W-1:0] nz(input logic [DIM_W-1:0] v);
    nz = (v == '0) ? DIM_W'(1) : v;
  endfunction

endpackage

// ===== hw/rtl/ttad_queue.sv =====
module ttad_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ttad_pkg::ent_t din,
  input  logic           pop,
  output ttad_pkg::ent_t dout,
  output logic           full,
  output logic           empty
);
  import ttad_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  ent_t             mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r;

  assign full  = (cnt_r == CNT_W'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/ttad_scale.sv =====
module ttad_scale (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ttad_pkg::DIM_W-1:0]   pw,
  input  logic [ttad_pkg::DIM_W-1:0]   ph,
  input  logic [ttad_pkg::DIM_W-1:0]   ow,
  input  logic [ttad_pkg::DIM_W-1:0]   oh,
  output logic                         busy,
  output logic [ttad_pkg::SCALE_W-1:0] even_scale,
  output logic [ttad_pkg::SCALE_W-1:0] odd_scale
);
  import ttad_pkg::*;

  localparam int PROD_W = 2 * DIM_W;
  localparam int NUM_W  = PROD_W + 16;
  localparam int IT_W   = $clog2(NUM_W);

  typedef enum logic [3:0] {
    SC_IDLE = 4'b0001,
    SC_MUL  = 4'b0010,
    SC_SEL  = 4'b0100,
    SC_DIV  = 4'b1000
  } sc_state_t;

  sc_state_t          state_r;
  logic [DIM_W-1:0]   pw_r, ph_r, ow_r, oh_r;
  logic [PROD_W-1:0]  p1_r, p2_r;
  logic [NUM_W-1:0]   num_r, q_r, q_nxt;
  logic [DIM_W-1:0]   den_r, rem_r, rem_nxt;
  logic [DIM_W:0]     rem_t;
  logic               ge;
  logic [IT_W-1:0]    it_r;
  logic               to_even_r;
  logic [SCALE_W-1:0] even_r, odd_r, res;

  assign busy       = (state_r != SC_IDLE);
  assign even_scale = even_r;
  assign odd_scale  = odd_r;

  // One restoring division step
  always_comb begin
    rem_t   = {rem_r, num_r[NUM_W-1]};
    ge      = (rem_t >= {1'b0, den_r});
    rem_nxt = ge ? DIM_W'(rem_t - {1'b0, den_r}) : rem_t[DIM_W-1:0];
    q_nxt   = {q_r[NUM_W-2:0], ge};
    res     = (q_nxt[NUM_W-1:SCALE_W] != '0) ? '1 : q_nxt[SCALE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      even_r  <= '0;
      odd_r   <= '0;
    end else begin
      unique case (state_r)
        SC_IDLE: begin
          if (start) begin
            pw_r    <= nz(pw);
            ph_r    <= nz(ph);
            ow_r    <= nz(ow);
            oh_r    <= nz(oh);
            state_r <= SC_MUL;
          end
        end
        SC_MUL: begin
          p1_r    <= PROD_W'(pw_r * oh_r);
          p2_r    <= PROD_W'(ph_r * ow_r);
          state_r <= SC_SEL;
        end
        SC_SEL: begin
          // Fit the tighter side; the other scale is a plain shift
          if (p1_r <= p2_r) begin
            num_r     <= {p2_r, 16'b0};
            den_r     <= pw_r;
            to_even_r <= 1'b1;
            odd_r     <= SCALE_W'({ow_r, 16'b0});
          end else begin
            num_r     <= {p1_r, 16'b0};
            den_r     <= ph_r;
            to_even_r <= 1'b0;
            even_r    <= SCALE_W'({oh_r, 16'b0});
          end
          rem_r   <= '0;
          q_r     <= '0;
          it_r    <= '0;
          state_r <= SC_DIV;
        end
        SC_DIV: begin
          rem_r <= rem_nxt;
          q_r   <= q_nxt;
          num_r <= num_r << 1;
          it_r  <= it_r + 1'b1;
          if (it_r == IT_W'(NUM_W - 1)) begin
            if (to_even_r) begin
              even_r <= res;
            end else begin
              odd_r <= res;
            end
            state_r <= SC_IDLE;
          end
        end
        default: state_r <= SC_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ttad_front.sv =====
module ttad_front #(
  parameter int VOCAB_SIZE = ttad_pkg::VOCAB_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ttad_pkg::PROB_W-1:0] in_prob,
  input  logic                        in_row_end,
  input  logic                        in_seq_end,
  input  ttad_pkg::loc_vec_t          in_loc,
  input  logic [ttad_pkg::TOK_W-1:0]  start_token,
  input  logic [ttad_pkg::TOK_W-1:0]  end_token,
  input  logic [ttad_pkg::MASK_W-1:0] cell_mask,
  input  ttad_pkg::fctl_t             ctl,
  output logic                        scale_start,
  output logic                        q_push,
  output ttad_pkg::ent_t              q_data
);
  import ttad_pkg::*;

  localparam int CNT_W = $clog2(VOCAB_SIZE);

  logic [PROB_W-1:0] best_r, best_nxt;
  logic [CNT_W-1:0]  bidx_r, bidx_nxt, cnt_r;
  logic              row_full_r, first_r, ended_r;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SC_W-1:0]   scnt_r, scnt_nxt;
  logic              new_seq, acc;
  logic [TOK_W-1:0]  idx;
  logic              is_start, is_end, tok, ends;

  // First element of a sequence waits until the back side has drained
  assign new_seq     = first_r && (cnt_r == '0) && !row_full_r;
  assign in_stall    = ctl.q_full ||
                       (new_seq && !(ctl.q_empty && ctl.back_idle && !ctl.scale_busy));
  assign acc         = in_valid && !in_stall;
  assign scale_start = acc && new_seq;

  // Running argmax, first maximum kept
  always_comb begin
    best_nxt = best_r;
    bidx_nxt = bidx_r;
    if (!row_full_r && ((cnt_r == '0) || (in_prob > best_r))) begin
      best_nxt = in_prob;
      bidx_nxt = cnt_r;
    end
  end

  // Row-end classification
  always_comb begin
    idx      = TOK_W'(bidx_nxt);
    is_start = (idx == start_token);
    is_end   = (idx == end_token);
    ends     = !ended_r && !first_r && is_end;
    tok      = !ended_r && !ends && !is_start && !is_end;
    sum_nxt  = sum_r;
    scnt_nxt = scnt_r;
    if (tok && (scnt_r < SC_W'(MAX_STEPS))) begin
      sum_nxt  = SUM_W'(sum_r + SUM_W'(best_nxt));
      scnt_nxt = scnt_r + 1'b1;
    end
  end

  assign q_push = acc && in_row_end && (tok || in_seq_end);

  always_comb begin
    q_data          = '0;
    q_data.tok      = tok;
    q_data.idx      = idx;
    q_data.cell_hit = cell_mask[idx];
    q_data.loc      = in_loc;
    q_data.done     = in_seq_end;
    q_data.sum      = sum_nxt;
    q_data.cnt      = scnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r     <= '0;
      bidx_r     <= '0;
      cnt_r      <= '0;
      row_full_r <= 1'b0;
      first_r    <= 1'b1;
      ended_r    <= 1'b0;
      sum_r      <= '0;
      scnt_r     <= '0;
    end else if (acc) begin
      best_r <= best_nxt;
      bidx_r <= bidx_nxt;
      if (!row_full_r) begin
        if (cnt_r == CNT_W'(VOCAB_SIZE - 1)) begin
          row_full_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (in_row_end) begin
        first_r    <= 1'b0;
        cnt_r      <= '0;
        row_full_r <= 1'b0;
        ended_r    <= ended_r | ends;
        sum_r      <= sum_nxt;
        scnt_r     <= scnt_nxt;
        if (in_seq_end) begin
          first_r <= 1'b1;
          ended_r <= 1'b0;
          sum_r   <= '0;
          scnt_r  <= '0;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/ttad_back.sv =====
module ttad_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  ttad_pkg::ent_t               q_data,
  output logic                         q_pop,
  input  logic                         scale_busy,
  input  logic [ttad_pkg::SCALE_W-1:0] even_scale,
  input  logic [ttad_pkg::SCALE_W-1:0] odd_scale,
  output logic                         back_idle,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ttad_pkg::TOK_W-1:0]   out_token_index,
  output logic                         out_is_cell,
  output ttad_pkg::loc_vec_t           out_box,
  output logic [ttad_pkg::PROB_W-1:0]  out_mean_score,
  output logic                         out_done_res
);
  import ttad_pkg::*;

  localparam int K_W   = $clog2(NUM_LOC);
  localparam int IT_W  = $clog2(SUM_W);
  localparam int PRD_W = PROB_W + SCALE_W;

  typedef enum logic [4:0] {
    BK_IDLE = 5'b00001,
    BK_MUL  = 5'b00010,
    BK_TOK  = 5'b00100,
    BK_DIV  = 5'b01000,
    BK_SUM  = 5'b10000
  } bk_state_t;

  bk_state_t         state_r;
  ent_t              e_r;
  loc_vec_t          box_r;
  logic [K_W-1:0]    k_r;
  logic [PRD_W-1:0]  prod;
  logic [SUM_W-1:0]  dnum_r, dq_r, dq_nxt;
  logic [SC_W-1:0]   drem_r, drem_nxt;
  logic [SC_W:0]     drem_t;
  logic              dge;
  logic [IT_W-1:0]   dit_r;
  logic [PROB_W-1:0] mean_r;

  assign back_idle = (state_r == BK_IDLE);
  assign q_pop     = back_idle && !q_empty && !scale_busy;

  // One box value per cycle; the product bits above SCALE_W give the 16-bit box
  assign prod = PRD_W'(e_r.loc[k_r]) * PRD_W'(k_r[0] ? odd_scale : even_scale);

  // Mean divider step
  always_comb begin
    drem_t   = {drem_r, dnum_r[SUM_W-1]};
    dge      = (drem_t >= {1'b0, e_r.cnt});
    drem_nxt = dge ? SC_W'(drem_t - {1'b0, e_r.cnt}) : drem_t[SC_W-1:0];
    dq_nxt   = {dq_r[SUM_W-2:0], dge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      unique case (state_r)
        BK_IDLE: begin
          if (q_pop) begin
            e_r    <= q_data;
            k_r    <= '0;
            dnum_r <= q_data.sum;
            drem_r <= '0;
            dq_r   <= '0;
            dit_r  <= '0;
            if (q_data.tok) begin
              state_r <= q_data.cell_hit ? BK_MUL : BK_TOK;
            end else begin
              state_r <= BK_DIV;
            end
          end
        end
        BK_MUL: begin
          box_r[k_r] <= prod[PRD_W-1:SCALE_W];
          k_r        <= k_r + 1'b1;
          if (k_r == K_W'(NUM_LOC - 1)) begin
            state_r <= BK_TOK;
          end
        end
        BK_TOK: begin
          if (!out_stall) begin
            state_r <= e_r.done ? BK_DIV : BK_IDLE;
          end
        end
        BK_DIV: begin
          drem_r <= drem_nxt;
          dq_r   <= dq_nxt;
          dnum_r <= dnum_r << 1;
          dit_r  <= dit_r + 1'b1;
          if (dit_r == IT_W'(SUM_W - 1)) begin
            mean_r  <= (e_r.cnt == '0) ? '0 : dq_nxt[PROB_W-1:0];
            state_r <= BK_SUM;
          end
        end
        BK_SUM: begin
          if (!out_stall) begin
            state_r <= BK_IDLE;
          end
        end
        default: state_r <= BK_IDLE;
      endcase
    end
  end

  // Result payload, zero where a field does not apply
  assign out_valid       = (state_r == BK_TOK) || (state_r == BK_SUM);
  assign out_token_index = (state_r == BK_TOK) ? e_r.idx : '0;
  assign out_is_cell     = (state_r == BK_TOK) && e_r.cell_hit;
  assign out_box         = ((state_r == BK_TOK) && e_r.cell_hit) ? box_r : '0;
  assign out_mean_score  = (state_r == BK_SUM) ? mean_r : '0;
  assign out_done_res    = (state_r == BK_SUM);

endmodule

// ===== hw/rtl/table_token_argmax_decoder_top.sv =====
// Greedy argmax decoder for table-structure token rows.
// Input channel (in_*): one probability per transaction; in_row_end marks the
// last element of a step row, in_seq_end with it closes the sequence. Box
// predictions in_loc_* are sampled on the row-end transaction.
// Output channel (out_*): one transaction per emitted token (index, cell flag,
// eight scaled boxes, zero unless a cell token), then a summary transaction
// (out_done_res) with the mean winning score when a sequence closes.
// Throughput: one element per cycle inside a row while the queue is not full.
// The first element of each sequence waits until earlier results have
// drained, then starts the scale divider (one quotient bit per cycle) that
// holds off results of the new sequence. A cell token passes through the
// shared 16x32 box multiplier, a summary through the mean divider. A two-entry
// queue between front and back keeps rows flowing while the back side works.
// Receiver stall holds the result; the queue then fills and in_stall rises.
// Reset (rst_n, synchronous) restores register defaults and starts a new
// sequence. The user must write the APB port (pready always high) only when
// idle; the block itself does not enforce this.
module table_token_argmax_decoder_top #(
  parameter int VOCAB_SIZE = ttad_pkg::VOCAB_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ttad_pkg::PROB_W-1:0] in_prob,
  input  logic                        in_row_end,
  input  logic                        in_seq_end,
  input  logic [ttad_pkg::PROB_W-1:0] in_loc_0,
  input  logic [ttad_pkg::PROB_W-1:0] in_loc_1,
  input  logic [ttad_pkg::PROB_W-1:0] in_loc_2,
  input  logic [ttad_pkg::PROB_W-1:0] in_loc_3,
  input  logic [ttad_pkg::PROB_W-1:0] in_loc_4,
  input  logic [ttad_pkg::PROB_W-1:0] in_loc_5,
  input  logic [ttad_pkg::PROB_W-1:0] in_loc_6,
  input  logic [ttad_pkg::PROB_W-1:0] in_loc_7,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ttad_pkg::TOK_W-1:0]  out_token_index,
  output logic                        out_is_cell,
  output logic [ttad_pkg::PROB_W-1:0] out_box_0,
  output logic [ttad_pkg::PROB_W-1:0] out_box_1,
  output logic [ttad_pkg::PROB_W-1:0] out_box_2,
  output logic [ttad_pkg::PROB_W-1:0] out_box_3,
  output logic [ttad_pkg::PROB_W-1:0] out_box_4,
  output logic [ttad_pkg::PROB_W-1:0] out_box_5,
  output logic [ttad_pkg::PROB_W-1:0] out_box_6,
  output logic [ttad_pkg::PROB_W-1:0] out_box_7,
  output logic [ttad_pkg::PROB_W-1:0] out_mean_score,
  output logic                        out_done_res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ttad_pkg::CFG_AW-1:0] paddr,
  input  logic [ttad_pkg::CFG_DW-1:0] pwdata,
  output logic [ttad_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import ttad_pkg::*;

  logic [DIM_W-1:0]   pw_r, ph_r, ow_r, oh_r;
  logic [TOK_W-1:0]   start_r, end_r;
  logic [MASK_W-1:0]  mask_r;
  logic               wr_en;
  logic [2:0]         reg_idx;
  loc_vec_t           in_loc, out_box;
  fctl_t              fctl;
  ent_t               q_din, q_dout;
  logic               q_push, q_pop, q_full, q_empty;
  logic               scale_start, scale_busy, back_idle;
  logic [SCALE_W-1:0] even_scale, odd_scale;

  // Register file
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw_r    <= DIM_W'(512);
      ph_r    <= DIM_W'(512);
      ow_r    <= DIM_W'(512);
      oh_r    <= DIM_W'(512);
      start_r <= TOK_W'(0);
      end_r   <= TOK_W'(1);
      mask_r  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PW:    pw_r    <= pwdata[DIM_W-1:0];
        REG_PH:    ph_r    <= pwdata[DIM_W-1:0];
        REG_OW:    ow_r    <= pwdata[DIM_W-1:0];
        REG_OH:    oh_r    <= pwdata[DIM_W-1:0];
        REG_START: start_r <= pwdata[TOK_W-1:0];
        REG_END:   end_r   <= pwdata[TOK_W-1:0];
        REG_MASK:  mask_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PW:    prdata = CFG_DW'(pw_r);
      REG_PH:    prdata = CFG_DW'(ph_r);
      REG_OW:    prdata = CFG_DW'(ow_r);
      REG_OH:    prdata = CFG_DW'(oh_r);
      REG_START: prdata = CFG_DW'(start_r);
      REG_END:   prdata = CFG_DW'(end_r);
      REG_MASK:  prdata = mask_r;
      default:   prdata = '0;
    endcase
  end

  assign in_loc = {in_loc_7, in_loc_6, in_loc_5, in_loc_4,
                   in_loc_3, in_loc_2, in_loc_1, in_loc_0};

  assign fctl.q_full     = q_full;
  assign fctl.q_empty    = q_empty;
  assign fctl.back_idle  = back_idle;
  assign fctl.scale_busy = scale_busy;

  ttad_front #(.VOCAB_SIZE(VOCAB_SIZE)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_prob     (in_prob),
    .in_row_end  (in_row_end),
    .in_seq_end  (in_seq_end),
    .in_loc      (in_loc),
    .start_token (start_r),
    .end_token   (end_r),
    .cell_mask   (mask_r),
    .ctl         (fctl),
    .scale_start (scale_start),
    .q_push      (q_push),
    .q_data      (q_din)
  );

  ttad_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (scale_start),
    .pw         (pw_r),
    .ph         (ph_r),
    .ow         (ow_r),
    .oh         (oh_r),
    .busy       (scale_busy),
    .even_scale (even_scale),
    .odd_scale  (odd_scale)
  );

  ttad_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  ttad_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_data          (q_dout),
    .q_pop           (q_pop),
    .scale_busy      (scale_busy),
    .even_scale      (even_scale),
    .odd_scale       (odd_scale),
    .back_idle       (back_idle),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_token_index (out_token_index),
    .out_is_cell     (out_is_cell),
    .out_box         (out_box),
    .out_mean_score  (out_mean_score),
    .out_done_res    (out_done_res)
  );

  assign out_box_0 = out_box[0];
  assign out_box_1 = out_box[1];
  assign out_box_2 = out_box[2];
  assign out_box_3 = out_box[3];
  assign out_box_4 = out_box[4];
  assign out_box_5 = out_box[5];
  assign out_box_6 = out_box[6];
  assign out_box_7 = out_box[7];

  // Queue never written when full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue written while full");

  // Back side never starts a row while scales are being computed
  a_pop_scales_ready: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !scale_busy)
    else $error("row popped during scale computation");

  // A new sequence starts only with the back side drained
  a_start_drained: assert property (@(posedge clk) disable iff (!rst_n)
    scale_start |-> (q_empty && back_idle && !out_valid))
    else $error("scale restart with results pending");

endmodule
